>>> design/lpfr_pkg.sv
// types and constants shared by the length-prefixed frame receiver
`timescale 1ns / 1ps
`default_nettype none
package lpfr_pkg;

    localparam int unsigned LEN_W = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 2;

    localparam logic [LEN_W-1:0] NULL_FRAME_MARK = 32'hFFFF_FFFF;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OVERSIZE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ZERO_LEN = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] out_byte;
        logic              frame_last;
    } t_result;

    // one result from the parser toward the output stage
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_result_xfer;

endpackage
`default_nettype wire

>>> design/lpfr_if.sv
// valid/ready channel interfaces for the byte input and the result output
`timescale 1ns / 1ps
`default_nettype none
interface lpfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface lpfr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       frame_last;

    modport source (output valid, output kind, output out_byte, output frame_last, input ready);
    modport sink (input valid, input kind, input out_byte, input frame_last, output ready);
endinterface
`default_nettype wire

>>> design/lpfr_parser.sv
// header collection, frame length tracking and result decode
`timescale 1ns / 1ps
`default_nettype none
module lpfr_parser (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [7:0]                 i_byte,
    input  wire logic                       i_cfg_we,
    input  wire logic [31:0]                i_cfg_wdata,
    output lpfr_pkg::t_result_xfer          o_xfer
);
    import lpfr_pkg::*;

    logic [LEN_W-1:0] r_size_limit, n_size_limit;
    logic [23:0]      r_hdr_shift, n_hdr_shift;
    logic [1:0]       r_hdr_count, n_hdr_count;
    logic [LEN_W-1:0] r_remain, n_remain;
    logic             r_skipping, n_skipping;
    logic             r_in_payload, n_in_payload;

    logic [LEN_W-1:0] hdr_len;
    logic             last_byte;

    assign hdr_len   = {r_hdr_shift, i_byte};
    assign last_byte = (r_remain == LEN_W'(1));

    always_comb begin
        n_size_limit = i_cfg_we ? i_cfg_wdata : r_size_limit;
        n_hdr_shift  = r_hdr_shift;
        n_hdr_count  = r_hdr_count;
        n_remain     = r_remain;
        n_skipping   = r_skipping;
        n_in_payload = r_in_payload;

        o_xfer.valid          = 1'b0;
        o_xfer.res.kind       = KIND_PAYLOAD;
        o_xfer.res.out_byte   = '0;
        o_xfer.res.frame_last = 1'b0;

        if (i_accept) begin
            if (!r_in_payload) begin
                if (r_hdr_count != 2'd3) begin
                    n_hdr_shift = {r_hdr_shift[15:0], i_byte};
                    n_hdr_count = r_hdr_count + 2'd1;
                end else begin
                    n_hdr_shift = '0;
                    n_hdr_count = '0;
                    // null marker is checked before the limit
                    if (hdr_len == NULL_FRAME_MARK) begin
                        n_in_payload = 1'b0;
                    end else if (hdr_len == '0) begin
                        o_xfer.valid    = 1'b1;
                        o_xfer.res.kind = KIND_ZERO_LEN;
                    end else begin
                        n_in_payload = 1'b1;
                        n_remain     = hdr_len;
                        if ((r_size_limit != '0) && (hdr_len > r_size_limit)) begin
                            n_skipping      = 1'b1;
                            o_xfer.valid    = 1'b1;
                            o_xfer.res.kind = KIND_OVERSIZE;
                        end else begin
                            n_skipping = 1'b0;
                        end
                    end
                end
            end else begin
                n_remain = r_remain - LEN_W'(1);
                if (last_byte) begin
                    n_in_payload = 1'b0;
                    n_skipping   = 1'b0;
                end
                if (!r_skipping) begin
                    o_xfer.valid          = 1'b1;
                    o_xfer.res.out_byte   = i_byte;
                    o_xfer.res.frame_last = last_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_limit <= '0;
            r_hdr_shift  <= '0;
            r_hdr_count  <= '0;
            r_skipping   <= 1'b0;
            r_in_payload <= 1'b0;
        end else begin
            r_size_limit <= n_size_limit;
            r_hdr_shift  <= n_hdr_shift;
            r_hdr_count  <= n_hdr_count;
            r_skipping   <= n_skipping;
            r_in_payload <= n_in_payload;
        end
    end

    // remaining count only matters while in_payload is set
    always_ff @(posedge i_clk) begin
        r_remain <= n_remain;
    end

endmodule
`default_nettype wire

>>> design/lpfr_out_stage.sv
// result register with a skid entry so input is taken while a result waits
`timescale 1ns / 1ps
`default_nettype none
module lpfr_out_stage (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire lpfr_pkg::t_result_xfer i_xfer,
    output logic                      o_room,
    output logic                      o_valid,
    output lpfr_pkg::t_result         o_res,
    input  wire logic                 i_ready
);
    import lpfr_pkg::*;

    logic    r_valid, n_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_data, n_data;
    t_result r_skid_data, n_skid_data;

    assign o_room  = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_res   = r_data;

    always_comb begin
        n_valid      = r_valid;
        n_skid_valid = r_skid_valid;
        n_data       = r_data;
        n_skid_data  = r_skid_data;
        if (!r_valid || i_ready) begin
            if (r_skid_valid) begin
                n_data       = r_skid_data;
                n_valid      = 1'b1;
                n_skid_valid = 1'b0;
            end else if (i_xfer.valid) begin
                n_data  = i_xfer.res;
                n_valid = 1'b1;
            end else begin
                n_valid = 1'b0;
            end
        end else if (i_xfer.valid) begin
            // output stalled: park the new result
            n_skid_data  = i_xfer.res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data      <= n_data;
        r_skid_data <= n_skid_data;
    end

endmodule
`default_nettype wire

>>> design/length_prefixed_frame_receiver_core.sv
// length-prefixed frame receiver: 4-byte big-endian header, streamed payload
// a result is registered into the output register, or parked in the skid entry while the output is stalled
// throughput: one byte per cycle while input ready is high; the parser state updates in the cycle of acceptance
// input ready falls only when both the result register and the skid entry are full
// reset (synchronous, active low) clears parser state, pending results and size_limit
`timescale 1ns / 1ps
`default_nettype none
module length_prefixed_frame_receiver_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lpfr_in_if.sink          i_in,
    lpfr_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata
);
    import lpfr_pkg::*;

    logic         in_accept;
    logic         room;
    logic         out_valid;
    t_result_xfer xfer;
    t_result      out_res;

    assign i_in.ready = room;
    assign in_accept  = i_in.valid && room;

    lpfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_byte      (i_in.in_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_xfer      (xfer)
    );

    lpfr_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_xfer  (xfer),
        .o_room  (room),
        .o_valid (out_valid),
        .o_res   (out_res),
        .i_ready (o_out.ready)
    );

    assign o_out.valid      = out_valid;
    assign o_out.kind       = out_res.kind;
    assign o_out.out_byte   = out_res.out_byte;
    assign o_out.frame_last = out_res.frame_last;

    // a full skid entry means the result register is occupied too
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("skid entry held without a pending result");

    // both entries full and output stalled: nothing can drain
    a_stall_holds_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_in.ready && !o_out.ready) |=> !i_in.ready)
        else $error("buffer drained while output stalled");

    a_last_only_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_last) |-> (o_out.kind == KIND_PAYLOAD))
        else $error("frame_last on a notice or error");

    a_notice_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind != KIND_PAYLOAD)) |-> (o_out.out_byte == 8'd0))
        else $error("nonzero byte on a notice or error");

endmodule
`default_nettype wire

>>> verif/length_prefixed_frame_receiver_core_tb.sv
// self-checking testbench for the length-prefixed frame receiver core
`timescale 1ns / 1ps
module length_prefixed_frame_receiver_core_tb;
    import lpfr_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;

    lpfr_in_if  in_ch ();
    lpfr_out_if out_ch ();

    length_prefixed_frame_receiver_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // receiver state as the testbench sees it
    logic [31:0] hdr_shift;
    logic [2:0]  hdr_cnt;
    logic [31:0] frm_len;
    logic [31:0] body_seen;
    logic        drop_body;
    logic        in_body;
    logic [31:0] size_limit_q;

    t_result pending_results[$];
    int      mismatch_count;
    int      bytes_sent;
    bit      idle_on;
    int      stall_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("length_prefixed_frame_receiver_core regression: fail");
        $finish;
    end

    // result side back-pressure
    initial begin
        out_ch.ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 8);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic void push_result(input logic [KIND_W-1:0] k, input logic [7:0] b,
                                        input logic last);
        t_result r;
        r.kind = k;
        r.out_byte = b;
        r.frame_last = last;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_rx_byte(input logic [7:0] b);
        logic [31:0] len;
        logic        last;
        if (!in_body) begin
            hdr_shift = {hdr_shift[23:0], b};
            hdr_cnt = hdr_cnt + 3'd1;
            if (hdr_cnt < 3'd4)
                return;
            len = hdr_shift;
            hdr_shift = '0;
            hdr_cnt = '0;
            // null marker wins over the size check
            if (len == NULL_FRAME_MARK)
                return;
            if (len == '0) begin
                push_result(KIND_ZERO_LEN, 8'h00, 1'b0);
                return;
            end
            frm_len = len;
            body_seen = '0;
            in_body = 1'b1;
            drop_body = (size_limit_q != '0) && (len > size_limit_q);
            if (drop_body)
                push_result(KIND_OVERSIZE, 8'h00, 1'b0);
            return;
        end
        body_seen = body_seen + 32'd1;
        last = (body_seen >= frm_len);
        if (!drop_body)
            push_result(KIND_PAYLOAD, b, last);
        if (last) begin
            in_body = 1'b0;
            drop_body = 1'b0;
            frm_len = '0;
            body_seen = '0;
        end
    endfunction

    // called in the time step of a rising edge; returns at the accepting edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [31:0] len);
        send_byte(len[31:24]);
        send_byte(len[23:16]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    task automatic send_frame(input logic [31:0] len);
        send_header(len);
        if (len != NULL_FRAME_MARK)
            for (int i = 0; i < int'(len); i++)
                send_byte(8'($urandom));
    endtask

    // no transaction in flight and every expected result seen
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_size_limit(input logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        size_limit_q = v;
    endtask

    task automatic test_null_frame();
        send_header(NULL_FRAME_MARK);
    endtask

    task automatic test_zero_length();
        send_header(32'h0000_0000);
    endtask

    task automatic test_short_frame();
        send_header(32'd2);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_null_under_limit();
        wait_quiet();
        write_size_limit(32'd1);
        send_header(NULL_FRAME_MARK);
    endtask

    // limit written while the oversize payload is still being dropped
    task automatic test_oversize_limit_change();
        send_header(32'd2);
        wait_quiet();
        write_size_limit(32'hFFFF_FFFF);
        send_byte(8'h5A);
        send_byte(8'hA5);
    endtask

    task automatic test_random_frames(input logic [31:0] limit, input bit idle, input int budget);
        int start;
        int pick;
        logic [31:0] len;
        wait_quiet();
        write_size_limit(limit);
        idle_on = idle;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                len = NULL_FRAME_MARK;
            else if (pick < 15)
                len = '0;
            else if (pick < 22)
                len = $urandom_range(13, 48);
            else
                len = $urandom_range(1, 12);
            send_frame(len);
        end
    endtask

    // a huge frame can never finish, so it closes the run
    task automatic test_open_long_frame();
        logic [31:0] len;
        wait_quiet();
        write_size_limit($urandom_range(1, 255));
        len = {1'b1, 31'($urandom)};
        if (len == NULL_FRAME_MARK)
            len[0] = 1'b0;
        send_header(len);
        repeat (12) send_byte(8'($urandom));
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result kind=%0d byte=%02h last=%0b", $time,
                         out_ch.kind, out_ch.out_byte, out_ch.frame_last);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.kind !== want.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind,
                             out_ch.kind);
                    mismatch_count++;
                end
                if (out_ch.out_byte !== want.out_byte) begin
                    $display("%0t: out_byte expected %02h actual %02h", $time,
                             want.out_byte, out_ch.out_byte);
                    mismatch_count++;
                end
                if (out_ch.frame_last !== want.frame_last) begin
                    $display("%0t: frame_last expected %0b actual %0b", $time,
                             want.frame_last, out_ch.frame_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        hdr_shift = '0;
        hdr_cnt = '0;
        frm_len = '0;
        body_seen = '0;
        drop_body = 1'b0;
        in_body = 1'b0;
        size_limit_q = '0;
        mismatch_count = 0;
        bytes_sent = 0;
        idle_on = 1'b1;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.in_byte <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_null_frame();
        test_zero_length();
        test_short_frame();
        test_null_under_limit();
        test_oversize_limit_change();
        test_random_frames(32'd0, 1'b1, 140);
        test_random_frames($urandom_range(1, 12), 1'b1, 140);
        test_random_frames(32'hFFFF_FFFF, 1'b1, 140);
        test_random_frames($urandom, 1'b1, 140);
        test_random_frames($urandom_range(1, 20), 1'b0, 140);
        idle_on = 1'b0;
        test_open_long_frame();

        wait_quiet();
        repeat (6) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("length_prefixed_frame_receiver_core regression: pass");
        else
            $display("length_prefixed_frame_receiver_core regression: fail");
        $finish;
    end
endmodule
